FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define AST_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: %m");

// Condition that must never be seen at a rising clock edge outside reset.
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen: %m");

`endif

FILE: hw/rtl/naa_pkg.sv
// Types, codes and arithmetic helpers for the neuron accumulate/activate unit.
package naa_pkg;

	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_DIRECT   = 2'd1;
	localparam logic [1:0] CMD_BACKWARD = 2'd2;

	localparam logic [1:0] MODE_SIGMOID = 2'd0;
	localparam logic [1:0] MODE_RELU    = 2'd1;
	localparam logic [1:0] MODE_IDENT   = 2'd2;

	localparam logic [16:0] Q_ONE   = 17'd65536;
	localparam logic [31:0] SIG_SAT = 32'd327680;  // 5.0
	localparam logic [31:0] SIG_MID = 32'd155648;  // 2.375
	localparam logic [31:0] SIG_LOW = 32'd65536;   // 1.0

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic               last_term;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               is_delta;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_EMIT
	} state_t;

	// Piecewise-linear sigmoid, result in [0, 1.0] as unsigned Q16.16.
	function automatic logic [16:0] pwl_sigmoid(input logic signed [31:0] x);
		logic [31:0] a;
		logic [16:0] y;
		a = x[31] ? (~x + 32'd1) : x;
		if (a >= SIG_SAT) begin
			y = Q_ONE;
		end else if (a >= SIG_MID) begin
			y = 17'(a >> 5) + 17'd55296;
		end else if (a >= SIG_LOW) begin
			y = 17'(a >> 3) + 17'd40960;
		end else begin
			y = 17'(a >> 2) + 17'd32768;
		end
		return x[31] ? (Q_ONE - y) : y;
	endfunction

	function automatic logic signed [31:0] activate(input logic [1:0] mode,
			input logic signed [31:0] x);
		logic signed [31:0] r;
		case (mode)
			MODE_SIGMOID: r = {15'd0, pwl_sigmoid(x)};
			MODE_RELU:    r = (x > 32'sd0) ? x : 32'sd0;
			default:      r = x;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/neuron_accumulate_activate_unit.sv
// Neuron accumulate/activate unit: top level with sequencer and shared multiplier.
//
// Usage:
//   req channel (req_valid/req_stall/req_item) carries one command per transaction:
//   add a weighted term (last_term closes the forward sum), load a direct value,
//   or run a backward step on a gradient. rsp channel (rsp_valid/rsp_stall/rsp_item)
//   returns the activated or stored value, or the delta with is_delta set.
//   cfg_we/cfg_data write the activation mode (0 sigmoid, 1 ReLU, 2 or 3 identity).
// Sequencing:
//   An accepted request occupies the unit until its result is in the output
//   register, passing CALC then EMIT; backward also passes MUL, running the single
//   18x33 multiplier twice (sigmoid slope, then slope times gradient). An add
//   without last_term, or an unused command code, gives no result and goes back
//   to idle after CALC. req_stall is high whenever the sequencer is not idle.
// Reset:
//   arst_n clears the sums, the mode (sigmoid) and all valid state at once.
// Backpressure:
//   The output register holds a transaction while rsp_stall is high; a finished
//   result waits in the sequencer until that register frees, so nothing is lost.
module neuron_accumulate_activate_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  naa_pkg::req_t req_item,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output naa_pkg::rsp_t rsp_item,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_data
);
	import naa_pkg::*;

	state_t state_q, state_d;

	// Captured request
	logic [1:0]         cmd_q;
	logic signed [31:0] val_q;
	logic               last_q;

	// Neuron state
	logic [1:0]         mode_q;
	logic signed [31:0] running_q;
	logic signed [31:0] latched_q;
	logic [16:0]        deriv_q;
	logic signed [31:0] result_q;
	logic               delta_q;

	// Output register
	logic out_valid_q;
	rsp_t out_q;

	// Sequencer outputs
	logic accept;
	logic calc_en;
	logic mul_en;
	logic emit_en;
	logic out_free;

	// Datapath nets
	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_sat;
	logic [16:0]        sig_s;
	logic [16:0]        deriv_d;
	logic signed [17:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [50:0] mul_p;
	logic signed [34:0] prod_sh;
	logic signed [31:0] delta_sat;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

	// Sequencer: next state and step enables
	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		calc_en = 1'b0;
		mul_en  = 1'b0;
		emit_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					accept  = 1'b1;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				calc_en = 1'b1;
				case (cmd_q)
					CMD_ADD:      state_d = last_q ? ST_EMIT : ST_IDLE;
					CMD_DIRECT:   state_d = ST_EMIT;
					CMD_BACKWARD: state_d = ST_MUL;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_en = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Saturating accumulator
	assign sum_ext = 33'(running_q) + 33'(val_q);
	always_comb begin
		if (sum_ext[32] != sum_ext[31]) begin
			sum_sat = sum_ext[32] ? S32_MIN : S32_MAX;
		end else begin
			sum_sat = sum_ext[31:0];
		end
	end

	// Shared multiplier: sigmoid slope s*(1-s) in CALC, slope*gradient in MUL
	assign sig_s = pwl_sigmoid(latched_q);
	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = {1'b0, deriv_q};
			mul_b = {val_q[31], val_q};
		end else begin
			mul_a = {1'b0, sig_s};
			mul_b = {16'd0, Q_ONE - sig_s};
		end
	end
	assign mul_p = mul_a * mul_b;

	// Derivative of the configured activation at the latched sum
	always_comb begin
		case (mode_q)
			MODE_SIGMOID: deriv_d = mul_p[32:16];
			MODE_RELU:    deriv_d = (latched_q > 32'sd0) ? Q_ONE : 17'd0;
			default:      deriv_d = Q_ONE;
		endcase
	end

	// Floor shift by 16, then clamp to 32 bits
	assign prod_sh = mul_p[50:16];
	always_comb begin
		if (!prod_sh[34] && (|prod_sh[33:31])) begin
			delta_sat = S32_MAX;
		end else if (prod_sh[34] && !(&prod_sh[33:31])) begin
			delta_sat = S32_MIN;
		end else begin
			delta_sat = prod_sh[31:0];
		end
	end

	// Configuration and neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SIGMOID;
			running_q <= '0;
			latched_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (calc_en && (cmd_q == CMD_ADD)) begin
				running_q <= last_q ? 32'sd0 : sum_sat;
				if (last_q) begin
					latched_q <= sum_sat;
				end
			end
		end
	end

	// Request capture and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req_item.command;
			val_q  <= req_item.value;
			last_q <= req_item.last_term;
		end
		if (calc_en) begin
			case (cmd_q)
				CMD_ADD: begin
					result_q <= activate(mode_q, sum_sat);
					delta_q  <= 1'b0;
				end
				CMD_DIRECT: begin
					result_q <= val_q;
					delta_q  <= 1'b0;
				end
				CMD_BACKWARD: begin
					deriv_q <= deriv_d;
				end
				default: begin
				end
			endcase
		end
		if (mul_en) begin
			result_q <= delta_sat;
			delta_q  <= 1'b1;
		end
		if (emit_en) begin
			out_q.result_value <= result_q;
			out_q.is_delta     <= delta_q;
		end
	end

	// Output valid: set on load, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/naa_checker.sv
// Port-level checker for the neuron accumulate/activate unit, with its bind.
`include "assert_macros.svh"

module naa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input naa_pkg::rsp_t rsp_item
);
	import naa_pkg::*;

	// Hold a stalled result transaction unchanged
	`AST_PROP(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))

	// Block further requests right after one is taken
	`AST_PROP(a_busy_after_accept, clk, arst_n, req_valid && !req_stall |=> req_stall)

	// A new result appears only as the sequencer finishes an item
	`AST_PROP(a_rsp_from_busy, clk, arst_n, $rose(rsp_valid) |-> $past(req_stall))

	// A new result never shows up in the cycle after a request is taken
	`AST_NEVER(a_no_overlap, clk, arst_n, $rose(rsp_valid) && $past(req_valid && !req_stall))

endmodule

bind neuron_accumulate_activate_unit naa_checker u_naa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);
